FILE: rtl/multi_channel_pulse_train_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse train generator
// Immediate-implication and next-cycle-implication property checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH
`define MULTI_CHANNEL_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define MCPTG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MCPTG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCPTG_ASSERT_IMP(lbl, ante, cons, msg)
`define MCPTG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/mcptg_pkg.sv
// ----------------------------------------------------------------------------
// mcptg_pkg
// Command codes, item layout and per-channel record types.
// ----------------------------------------------------------------------------
package mcptg_pkg;

    localparam logic [2:0] FUNC_TICK        = 3'd0;
    localparam logic [2:0] FUNC_START       = 3'd1;
    localparam logic [2:0] FUNC_START_COUNT = 3'd2;
    localparam logic [2:0] FUNC_RESTART     = 3'd3;
    localparam logic [2:0] FUNC_STOP        = 3'd4;
    localparam logic [2:0] FUNC_FORCE       = 3'd5;
    localparam logic [2:0] FUNC_LOAD        = 3'd6;
    localparam logic [2:0] FUNC_NONE        = 3'd7;

    localparam int          ADDR_W              = 3;
    localparam logic [2:0]  ADDR_CHANNELS_IN_USE = 3'd0;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic close_active;
        logic start_active;
        logic reverse_polarity;
        logic endless;
    } mode_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  channel;
        logic [15:0] elapsed_ms;
        logic [31:0] pulse_count;
        logic        level;
        logic [31:0] on_period;
        logic [31:0] off_period;
        logic [31:0] total_toggles;
        mode_t       mode;
    } item_t;

    typedef struct packed {
        logic [31:0] on_period;
        logic [31:0] off_period;
        logic [31:0] total_toggles;
        mode_t       mode;
    } setting_t;

    typedef struct packed {
        logic [31:0] elapsed;
        logic [31:0] toggles;
    } runtime_t;

    typedef struct packed {
        logic  valid;
        item_t head;
    } queue_head_t;

endpackage

FILE: rtl/mcptg_ram.sv
// ----------------------------------------------------------------------------
// mcptg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcptg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/mcptg_front.sv
// ----------------------------------------------------------------------------
// mcptg_front
// Accepts request beats, drops those that act on nothing, queues the rest.
// ----------------------------------------------------------------------------
module mcptg_front import mcptg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  item_t       req_item,
    output logic        req_stall,
    input  logic [5:0]  n_act,
    output queue_head_t q_out,
    input  logic        q_pop
);

    item_t      slot_reg [QDEPTH];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    logic       keep;
    logic       push;
    logic       pop;

    always_comb
    begin
        if (req_item.func == FUNC_TICK)
        begin
            keep = (n_act != 6'd0);
        end
        else
        begin
            keep = (req_item.func != FUNC_NONE) && ({1'b0, req_item.channel} < n_act);
        end
    end

    assign req_stall = (cnt_reg == 2'(QDEPTH));
    assign accept    = req_valid && !req_stall;
    assign push      = accept && keep;
    assign pop       = q_pop && (cnt_reg != 2'd0);

    assign wptr_next = push ? ~wptr_reg : wptr_reg;
    assign rptr_next = pop ? ~rptr_reg : rptr_reg;
    assign cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= req_item;
        end
    end

    assign q_out.valid = (cnt_reg != 2'd0);
    assign q_out.head  = slot_reg[rptr_reg];

    `include "multi_channel_pulse_train_generator_top_assert.svh"

    `MCPTG_ASSERT_NXT(a_queue_grows, (push && !pop), (cnt_reg == $past(cnt_reg) + 2'd1), "queue count did not grow on push")

endmodule

FILE: rtl/mcptg_back.sv
// ----------------------------------------------------------------------------
// mcptg_back
// Executes queued commands and tick sweeps against the channel records.
// ----------------------------------------------------------------------------
module mcptg_back import mcptg_pkg::*; #(
    parameter int CHANNELS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t q_in,
    output logic        q_pop,
    input  logic [5:0]  n_act,
    input  logic        pin_stall,
    output logic        pin_valid,
    output logic [4:0]  pin_channel,
    output logic        pin_level,
    output logic        last
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW   = ((CH_W > 6) ? CH_W : 6) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMD   = 2'd1;
    localparam logic [1:0] ST_TICK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]      state_reg, state_next;
    item_t           item_reg, item_next;
    logic [CH_W-1:0] idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [4:0]      pend_ch_reg, pend_ch_next;
    logic            pend_lvl_reg, pend_lvl_next;
    logic [CHANNELS-1:0] enabled_reg;
    logic [CHANNELS-1:0] phase_reg;
    logic            ov_reg, ov_next;
    logic [4:0]      och_reg;
    logic            olvl_reg;
    logic            olast_reg;

    logic                         set_we;
    logic [CH_W-1:0]              set_waddr;
    setting_t                     set_wrec;
    logic [$bits(setting_t)-1:0]  set_rdata;
    logic                         rt_we;
    runtime_t                     rt_wrec;
    logic [$bits(runtime_t)-1:0]  rt_rdata;
    logic                         rd_en;
    logic [CH_W-1:0]              rd_addr;

    setting_t        st;
    runtime_t        rt;
    logic [CH_W-1:0] cidx;
    logic            en_c;
    logic            ph_c;
    logic            can_push;

    logic [31:0] period;
    logic [31:0] sum;
    logic [31:0] diff;
    logic [31:0] tog_m1;
    logic        reach;
    logic        dec;
    logic        ends;
    logic        t_res;
    logic        t_lvl;
    logic        at_end;

    logic        start_go;
    logic [31:0] count_c;
    logic        c_res;
    logic        c_lvl;

    logic        flag_we;
    logic        en_new;
    logic        ph_new;
    logic        push;
    logic [4:0]  push_ch;
    logic        push_lvl;
    logic        push_last;

    mcptg_ram #(.WIDTH($bits(setting_t)), .DEPTH(CHANNELS)) u_set_ram (
        .clk   (clk),
        .we    (set_we),
        .waddr (set_waddr),
        .wdata (set_wrec),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (set_rdata)
    );

    mcptg_ram #(.WIDTH($bits(runtime_t)), .DEPTH(CHANNELS)) u_rt_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (cidx),
        .wdata (rt_wrec),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rt_rdata)
    );

    assign st       = setting_t'(set_rdata);
    assign rt       = runtime_t'(rt_rdata);
    assign cidx     = (state_reg == ST_TICK) ? idx_reg : CH_W'(item_reg.channel);
    assign en_c     = enabled_reg[cidx];
    assign ph_c     = phase_reg[cidx];
    assign can_push = !ov_reg || !pin_stall;

    // tick update for the channel whose record sits on the read port
    assign period = ph_c ? st.on_period : st.off_period;
    assign sum    = rt.elapsed + 32'(item_reg.elapsed_ms);
    assign diff   = sum - period;
    assign reach  = (sum >= period);
    assign tog_m1 = rt.toggles - 32'd1;
    assign dec    = !st.mode.endless && (rt.toggles != 32'd0);
    assign ends   = reach && dec && (tog_m1 == 32'd0);
    assign t_res  = en_c && reach;
    assign t_lvl  = (ends ? st.mode.close_active : !ph_c) ^ st.mode.reverse_polarity;
    assign at_end = (IW'(idx_reg) + IW'(1)) == IW'(n_act);

    // command decode
    assign start_go = ((item_reg.func == FUNC_START) && !en_c)
                   || (item_reg.func inside {FUNC_START_COUNT, FUNC_RESTART});
    assign count_c  = (item_reg.func == FUNC_START_COUNT) ? item_reg.pulse_count
                                                          : st.total_toggles;

    always_comb
    begin
        c_res = 1'b0;
        c_lvl = 1'b0;
        case (item_reg.func)
            FUNC_START, FUNC_START_COUNT, FUNC_RESTART:
            begin
                c_res = start_go && st.mode.start_active;
                c_lvl = !st.mode.reverse_polarity;
            end
            FUNC_STOP:
            begin
                c_res = 1'b1;
                c_lvl = st.mode.close_active ^ st.mode.reverse_polarity;
            end
            FUNC_FORCE:
            begin
                c_res = 1'b1;
                c_lvl = item_reg.level ^ st.mode.reverse_polarity;
            end
            default:
            begin
                c_res = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_ch_next  = pend_ch_reg;
        pend_lvl_next = pend_lvl_reg;
        q_pop         = 1'b0;
        set_we        = 1'b0;
        set_waddr     = CH_W'(q_in.head.channel);
        set_wrec      = '{on_period:     q_in.head.on_period,
                          off_period:    q_in.head.off_period,
                          total_toggles: q_in.head.total_toggles,
                          mode:          q_in.head.mode};
        rt_we         = 1'b0;
        rt_wrec       = '{elapsed: 32'd0, toggles: 32'd0};
        rd_en         = 1'b0;
        rd_addr       = '0;
        flag_we       = 1'b0;
        en_new        = 1'b0;
        ph_new        = 1'b0;
        push          = 1'b0;
        push_ch       = pend_ch_reg;
        push_lvl      = pend_lvl_reg;
        push_last     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_in.head;
                    case (q_in.head.func)
                        FUNC_LOAD:
                        begin
                            set_we = 1'b1;
                        end
                        FUNC_TICK:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = ST_TICK;
                        end
                        default:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = CH_W'(q_in.head.channel);
                            state_next = ST_CMD;
                        end
                    endcase
                end
            end
            ST_CMD:
            begin
                if (!c_res || can_push)
                begin
                    if (start_go)
                    begin
                        rt_we   = 1'b1;
                        rt_wrec = '{elapsed: 32'd0,
                                    toggles: st.mode.start_active ? count_c - 32'd1 : count_c};
                        flag_we = 1'b1;
                        en_new  = 1'b1;
                        ph_new  = st.mode.start_active ? 1'b1 : ph_c;
                    end
                    else if (item_reg.func == FUNC_STOP)
                    begin
                        flag_we = 1'b1;
                    end
                    push       = c_res;
                    push_ch    = item_reg.channel;
                    push_lvl   = c_lvl;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                // hold the channel while the previous result cannot leave
                if (!(t_res && pend_reg) || can_push)
                begin
                    if (en_c)
                    begin
                        rt_we   = 1'b1;
                        rt_wrec = '{elapsed: ends ? 32'd0 : (reach ? diff : sum),
                                    toggles: (reach && dec) ? tog_m1 : rt.toggles};
                        flag_we = 1'b1;
                        en_new  = !ends;
                        ph_new  = ends ? 1'b0 : (reach ? !ph_c : ph_c);
                    end
                    if (t_res)
                    begin
                        push          = pend_reg;
                        pend_next     = 1'b1;
                        pend_ch_next  = 5'(idx_reg);
                        pend_lvl_next = t_lvl;
                    end
                    if (at_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + CH_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + CH_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_push)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ov_next = push ? 1'b1 : (pin_stall ? ov_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            ov_reg      <= 1'b0;
            enabled_reg <= '0;
            phase_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            if (flag_we)
            begin
                enabled_reg[cidx] <= en_new;
                phase_reg[cidx]   <= ph_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        pend_ch_reg  <= pend_ch_next;
        pend_lvl_reg <= pend_lvl_next;
        if (push)
        begin
            och_reg   <= push_ch;
            olvl_reg  <= push_lvl;
            olast_reg <= push_last;
        end
    end

    assign pin_valid   = ov_reg;
    assign pin_channel = och_reg;
    assign pin_level   = olvl_reg;
    assign last        = olast_reg;

    `include "multi_channel_pulse_train_generator_top_assert.svh"

    `MCPTG_ASSERT_IMP(a_idle_no_pend, (state_reg == ST_IDLE), (!pend_reg), "pending result left in idle")
    `MCPTG_ASSERT_IMP(a_push_room, push, can_push, "result beat overwrote a waiting beat")
    `MCPTG_ASSERT_IMP(a_mid_only_tick, (push && !push_last), (state_reg == ST_TICK), "non-final beat outside a sweep")
    `MCPTG_ASSERT_NXT(a_last_to_idle, (push && push_last), (state_reg == ST_IDLE), "final beat did not end the item")

endmodule

FILE: rtl/multi_channel_pulse_train_generator_top.sv
// ----------------------------------------------------------------------------
// multi_channel_pulse_train_generator_top
// Per-channel on/off pulse trains with a command queue and a tick sweeper.
//
//   channel  | handshake            | beat
//   ---------+----------------------+-----------------------------------------
//   request  | req_valid/req_stall  | func, channel, timing and mode fields
//   pin      | pin_valid/pin_stall  | pin_channel, pin_level, last
//   config   | APB, pready tied 1   | channels_in_use at byte address 0
//
// A command reads its channel records as it leaves the queue head and
// presents its pin beat from the output register. A tick sweeps the channels
// in use, one channel per cycle through the settings and runtime RAM read
// ports, except that a stalled pin beat holds the sweep on the next channel
// that changes a pin. Reset clears enabled and phase flags at once; the RAMs
// need no clearing pass. The request side is buffered by a two-entry queue.
// ----------------------------------------------------------------------------
module multi_channel_pulse_train_generator_top import mcptg_pkg::*; #(
    parameter int CHANNELS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [2:0]        func,
    input  logic [4:0]        channel,
    input  logic [15:0]       elapsed_ms,
    input  logic [31:0]       pulse_count,
    input  logic              level,
    input  logic [31:0]       on_period,
    input  logic [31:0]       off_period,
    input  logic [31:0]       total_toggles,
    input  logic              endless,
    input  logic              reverse_polarity,
    input  logic              start_active,
    input  logic              close_active,
    output logic              pin_valid,
    input  logic              pin_stall,
    output logic [4:0]        pin_channel,
    output logic              pin_level,
    output logic              last
);

    localparam int CAP = (CHANNELS < 63) ? CHANNELS : 63;

    logic [5:0]  ciu_reg, ciu_next;
    logic        cfg_wr;
    logic [5:0]  n_act;
    item_t       req_item;
    queue_head_t q_head;
    logic        q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CHANNELS_IN_USE);
    assign ciu_next = cfg_wr ? pwdata[5:0] : ciu_reg;
    assign prdata = (paddr == ADDR_CHANNELS_IN_USE) ? {26'd0, ciu_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ciu_reg <= 6'd0;
        end
        else
        begin
            ciu_reg <= ciu_next;
        end
    end

    assign n_act = (ciu_reg < 6'(CAP)) ? ciu_reg : 6'(CAP);

    assign req_item = '{func:          func,
                        channel:       channel,
                        elapsed_ms:    elapsed_ms,
                        pulse_count:   pulse_count,
                        level:         level,
                        on_period:     on_period,
                        off_period:    off_period,
                        total_toggles: total_toggles,
                        mode:          '{close_active:     close_active,
                                         start_active:     start_active,
                                         reverse_polarity: reverse_polarity,
                                         endless:          endless}};

    mcptg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_item  (req_item),
        .req_stall (req_stall),
        .n_act     (n_act),
        .q_out     (q_head),
        .q_pop     (q_pop)
    );

    mcptg_back #(.CHANNELS(CHANNELS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_in        (q_head),
        .q_pop       (q_pop),
        .n_act       (n_act),
        .pin_stall   (pin_stall),
        .pin_valid   (pin_valid),
        .pin_channel (pin_channel),
        .pin_level   (pin_level),
        .last        (last)
    );

endmodule

FILE: bench/pulse_train_checker.sv
// ----------------------------------------------------------------------------
// Pulse train pin checker
// Watches the config, request and pin channels of the pulse train generator.
// Keeps its own copy of the per-channel settings and runtime state, works out
// the pin writes each request beat causes and compares every pin beat, in
// order, against the oldest pin write still due.
// ----------------------------------------------------------------------------
module pulse_train_checker import mcptg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              req_valid,
    input  logic              req_stall,
    input  logic [2:0]        func,
    input  logic [4:0]        channel,
    input  logic [15:0]       elapsed_ms,
    input  logic [31:0]       pulse_count,
    input  logic              level,
    input  logic [31:0]       on_period,
    input  logic [31:0]       off_period,
    input  logic [31:0]       total_toggles,
    input  logic              endless,
    input  logic              reverse_polarity,
    input  logic              start_active,
    input  logic              close_active,
    input  logic              pin_valid,
    input  logic              pin_stall,
    input  logic [4:0]        pin_channel,
    input  logic              pin_level,
    input  logic              last,
    output int                pins_outstanding,
    output int                mismatch_count
);

    localparam int NCH = 32;

    typedef struct packed {
        logic [4:0] chan;
        logic       lvl;
        logic       fin;
    } pin_write_t;

    logic [5:0]  chans_in_use;
    logic        running [NCH];
    logic        phase_on [NCH];
    logic [31:0] elapsed_acc [NCH];
    logic [31:0] toggles_left [NCH];
    logic [31:0] on_ms [NCH];
    logic [31:0] off_ms [NCH];
    logic [31:0] total_cnt [NCH];
    mode_t       mode_tab [NCH];

    pin_write_t  pins_due [$];
    item_t       req_beat;
    pin_write_t  got;
    pin_write_t  want;

    function automatic pin_write_t pin_at(input int ch, input logic on);
        pin_write_t p;
        p.chan = ch[4:0];
        p.lvl  = on ^ mode_tab[ch].reverse_polarity;
        p.fin  = 1'b0;
        return p;
    endfunction

    // Returns 1 when the train opens in the active phase and drives the pin.
    function automatic logic arm_train(input int ch, input logic [31:0] count);
        running[ch]      = 1'b1;
        elapsed_acc[ch]  = '0;
        toggles_left[ch] = count;
        if (mode_tab[ch].start_active)
        begin
            toggles_left[ch] = count - 32'd1;
            phase_on[ch]     = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_pin_writes(input item_t it);
        pin_write_t  batch [$];
        int          n;
        int          ch;
        logic [31:0] period;
        logic        closing;
        n  = (chans_in_use > 6'd32) ? NCH : int'(chans_in_use);
        ch = int'(it.channel);
        if (it.func == FUNC_TICK)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (running[i])
                begin
                    period = phase_on[i] ? on_ms[i] : off_ms[i];
                    elapsed_acc[i] = elapsed_acc[i] + {16'd0, it.elapsed_ms};
                    if (elapsed_acc[i] >= period)
                    begin
                        elapsed_acc[i] = elapsed_acc[i] - period;
                        phase_on[i]    = ~phase_on[i];
                        closing        = 1'b0;
                        if (!mode_tab[i].endless && toggles_left[i] != 32'd0)
                        begin
                            toggles_left[i] = toggles_left[i] - 32'd1;
                            closing         = (toggles_left[i] == 32'd0);
                        end
                        if (closing)
                        begin
                            // train ran out: park the pin at its close level
                            elapsed_acc[i] = '0;
                            phase_on[i]    = 1'b0;
                            running[i]     = 1'b0;
                            batch.push_back(pin_at(i, mode_tab[i].close_active));
                        end
                        else
                        begin
                            batch.push_back(pin_at(i, phase_on[i]));
                        end
                    end
                end
            end
        end
        else if (ch < n)
        begin
            case (it.func)
                FUNC_START:
                begin
                    if (!running[ch])
                    begin
                        if (arm_train(ch, total_cnt[ch]))
                            batch.push_back(pin_at(ch, 1'b1));
                    end
                end
                FUNC_START_COUNT:
                begin
                    if (arm_train(ch, it.pulse_count))
                        batch.push_back(pin_at(ch, 1'b1));
                end
                FUNC_RESTART:
                begin
                    if (arm_train(ch, total_cnt[ch]))
                        batch.push_back(pin_at(ch, 1'b1));
                end
                FUNC_STOP:
                begin
                    running[ch]  = 1'b0;
                    phase_on[ch] = 1'b0;
                    batch.push_back(pin_at(ch, mode_tab[ch].close_active));
                end
                FUNC_FORCE:
                begin
                    batch.push_back(pin_at(ch, it.level));
                end
                FUNC_LOAD:
                begin
                    on_ms[ch]     = it.on_period;
                    off_ms[ch]    = it.off_period;
                    total_cnt[ch] = it.total_toggles;
                    mode_tab[ch]  = it.mode;
                end
                default:
                begin
                end
            endcase
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].fin = 1'b1;
        foreach (batch[j])
            pins_due.push_back(batch[j]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_in_use = '0;
            for (int i = 0; i < NCH; i++)
            begin
                running[i]      = 1'b0;
                phase_on[i]     = 1'b0;
                elapsed_acc[i]  = '0;
                toggles_left[i] = '0;
                on_ms[i]        = '0;
                off_ms[i]       = '0;
                total_cnt[i]    = '0;
                mode_tab[i]     = '0;
            end
            pins_due.delete();
            pins_outstanding = 0;
            mismatch_count   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_CHANNELS_IN_USE)
                chans_in_use = pwdata[5:0];

            if (req_valid && !req_stall)
            begin
                req_beat.func                  = func;
                req_beat.channel               = channel;
                req_beat.elapsed_ms            = elapsed_ms;
                req_beat.pulse_count           = pulse_count;
                req_beat.level                 = level;
                req_beat.on_period             = on_period;
                req_beat.off_period            = off_period;
                req_beat.total_toggles         = total_toggles;
                req_beat.mode.endless          = endless;
                req_beat.mode.reverse_polarity = reverse_polarity;
                req_beat.mode.start_active     = start_active;
                req_beat.mode.close_active     = close_active;
                predict_pin_writes(req_beat);
            end

            if (pin_valid && !pin_stall)
            begin
                got.chan = pin_channel;
                got.lvl  = pin_level;
                got.fin  = last;
                if (pins_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pin beat with nothing due: channel %0d level %0b last %0b",
                                 got.chan, got.lvl, got.fin);
                end
                else
                begin
                    want = pins_due.pop_front();
                    if (got.chan !== want.chan || got.lvl !== want.lvl ||
                        got.fin !== want.fin)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"pin beat mismatch: expected ch %0d lvl %0b last %0b,",
                                      " got ch %0d lvl %0b last %0b"},
                                     want.chan, want.lvl, want.fin,
                                     got.chan, got.lvl, got.fin);
                    end
                end
            end
            pins_outstanding = pins_due.size();
        end
    end

endmodule

FILE: bench/tb_multi_channel_pulse_train_generator_top.sv
// ----------------------------------------------------------------------------
// Pulse train generator testbench
// Programs the channel count over APB, runs a directed command sequence and
// then random command/tick traffic with random valid gaps and pin stalls, a
// long pin hold-off and a gap-free stretch. The checker predicts and compares
// every pin beat; this module only drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_multi_channel_pulse_train_generator_top import mcptg_pkg::*; ();

    logic              clk              = 1'b0;
    logic              rst_n            = 1'b0;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [ADDR_W-1:0] paddr            = '0;
    logic [31:0]       pwdata           = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              req_valid        = 1'b0;
    logic              req_stall;
    logic [2:0]        func             = '0;
    logic [4:0]        channel          = '0;
    logic [15:0]       elapsed_ms       = '0;
    logic [31:0]       pulse_count      = '0;
    logic              level            = 1'b0;
    logic [31:0]       on_period        = '0;
    logic [31:0]       off_period       = '0;
    logic [31:0]       total_toggles    = '0;
    logic              endless          = 1'b0;
    logic              reverse_polarity = 1'b0;
    logic              start_active     = 1'b0;
    logic              close_active     = 1'b0;
    logic              pin_valid;
    logic              pin_stall        = 1'b0;
    logic [4:0]        pin_channel;
    logic              pin_level;
    logic              last;

    int   pins_outstanding;
    int   mismatch_count;

    logic hold_off   = 1'b0;
    logic calm       = 1'b0;
    logic squeeze_go = 1'b0;
    logic loaded [32];
    int   in_use;
    int   random_sent;

    multi_channel_pulse_train_generator_top #(.CHANNELS(32)) u_top (.*);

    pulse_train_checker u_checker (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
        pin_stall <= hold_off || (!calm && $urandom_range(0, 99) < 27);

    // Long receiver hold-off so the request queue fills and backs up.
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] pick_period();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, 30);
        else if (roll < 90)
            return $urandom_range(0, 200);
        return $urandom;
    endfunction

    function automatic item_t make_cmd(input logic [2:0] f, input int ch);
        item_t it;
        it.func          = f;
        it.channel       = ch[4:0];
        it.elapsed_ms    = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 40))
                                                        : 16'($urandom);
        it.pulse_count   = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 10) : $urandom;
        it.level         = 1'($urandom);
        it.on_period     = pick_period();
        it.off_period    = pick_period();
        it.total_toggles = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 8) :
                           ($urandom_range(0, 99) < 75) ? $urandom_range(0, 40) : $urandom;
        it.mode          = 4'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic send_request(input item_t it);
        while (!calm && $urandom_range(0, 99) < 27)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid        <= 1'b1;
        func             <= it.func;
        channel          <= it.channel;
        elapsed_ms       <= it.elapsed_ms;
        pulse_count      <= it.pulse_count;
        level            <= it.level;
        on_period        <= it.on_period;
        off_period       <= it.off_period;
        total_toggles    <= it.total_toggles;
        endless          <= it.mode.endless;
        reverse_polarity <= it.mode.reverse_polarity;
        start_active     <= it.mode.start_active;
        close_active     <= it.mode.close_active;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (it.func == FUNC_LOAD && int'(it.channel) < in_use)
            loaded[it.channel] = 1'b1;
    endtask

    task automatic send_cmd(input logic [2:0] f, input int ch, input logic [31:0] arg);
        item_t it;
        it = make_cmd(f, ch);
        case (f)
            FUNC_TICK:        it.elapsed_ms  = arg[15:0];
            FUNC_START_COUNT: it.pulse_count = arg;
            FUNC_FORCE:       it.level       = arg[0];
            default:          it.level       = it.level;
        endcase
        send_request(it);
    endtask

    task automatic send_load(input int ch, input logic [31:0] on_p, input logic [31:0] off_p,
                             input logic [31:0] tot, input logic [3:0] mb);
        item_t it;
        it               = make_cmd(FUNC_LOAD, ch);
        it.on_period     = on_p;
        it.off_period    = off_p;
        it.total_toggles = tot;
        it.mode          = mb;
        send_request(it);
    endtask

    // Draw one request; ignored is set when the block will drop it.
    function automatic item_t random_request(input int n, output logic ignored);
        item_t it;
        int    ch;
        int    roll;
        ignored = 1'b0;
        roll    = $urandom_range(0, 99);
        if (n == 0 || roll < 5)
        begin
            ignored = 1'b1;
            if (n >= 32)
                return make_cmd(FUNC_NONE, $urandom_range(0, 31));
            return make_cmd(3'($urandom_range(1, 7)), $urandom_range(n, 31));
        end
        ch = $urandom_range(0, n - 1);
        if (!loaded[ch])
            return make_cmd(FUNC_LOAD, ch);
        roll = $urandom_range(0, 99);
        if (roll < 40)
            it = make_cmd(FUNC_TICK, $urandom_range(0, 31));
        else if (roll < 52)
            it = make_cmd(FUNC_LOAD, ch);
        else if (roll < 62)
            it = make_cmd(FUNC_START, ch);
        else if (roll < 70)
            it = make_cmd(FUNC_START_COUNT, ch);
        else if (roll < 78)
            it = make_cmd(FUNC_RESTART, ch);
        else if (roll < 89)
            it = make_cmd(FUNC_STOP, ch);
        else
            it = make_cmd(FUNC_FORCE, ch);
        return it;
    endfunction

    task automatic drain(input int settle);
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pins_outstanding != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Wait out queued and running sweeps that drive no pin before reprogramming.
    task automatic set_channels_in_use(input int v);
        drain(200);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_CHANNELS_IN_USE;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        in_use = v;
    endtask

    initial
    begin
        int     settings [7];
        int     budget [7];
        int     k;
        logic   ignored;
        item_t  it;

        settings = '{5, 1, 0, 17, 32, 3, 32};
        budget   = '{50, 30, 12, 70, 120, 40, 50};
        in_use      = 0;
        random_sent = 0;
        foreach (loaded[i])
            loaded[i] = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_channels_in_use(32);

        send_cmd(FUNC_NONE, 0, 0);
        send_load(0, 32'd3, 32'd2, 32'd5, 4'b1100);
        send_load(1, 32'd0, 32'd0, 32'd0, 4'b0010);
        send_load(2, 32'd10, 32'd10, 32'd3, 4'b1111);
        send_load(3, 32'd1, 32'd1, 32'd1, 4'b0100);
        send_load(31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b1001);
        send_cmd(FUNC_START, 0, 0);
        send_cmd(FUNC_START, 0, 0);
        send_cmd(FUNC_START, 1, 0);
        // start-active with a zero count wraps the count down
        send_cmd(FUNC_START_COUNT, 3, 32'd0);
        send_cmd(FUNC_RESTART, 2, 0);
        send_cmd(FUNC_START, 31, 0);
        send_cmd(FUNC_FORCE, 31, 32'd1);
        send_cmd(FUNC_FORCE, 1, 32'd0);
        send_cmd(FUNC_TICK, 0, 32'd0);
        send_cmd(FUNC_TICK, 17, 32'd3);
        send_cmd(FUNC_TICK, 31, 32'h0000_FFFF);
        send_cmd(FUNC_TICK, 10, 32'd5);
        send_cmd(FUNC_STOP, 2, 0);
        send_cmd(FUNC_STOP, 31, 0);
        send_cmd(FUNC_START_COUNT, 0, 32'hFFFF_FFFF);
        send_cmd(FUNC_TICK, 21, 32'd1);
        send_cmd(FUNC_TICK, 6, 32'd2);

        foreach (settings[p])
        begin
            set_channels_in_use(settings[p]);
            k = 0;
            while (k < budget[p])
            begin
                it = random_request(in_use, ignored);
                send_request(it);
                if (!ignored || in_use == 0)
                    k++;
                if (!ignored)
                    random_sent++;
                if (random_sent == 180)
                    squeeze_go <= 1'b1;
                if (random_sent == 230)
                    calm <= 1'b1;
                if (random_sent == 300)
                    calm <= 1'b0;
            end
        end

        drain(100);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: multi_channel_pulse_train_generator_top.f
+incdir+rtl
rtl/mcptg_pkg.sv
rtl/mcptg_ram.sv
rtl/mcptg_front.sv
rtl/mcptg_back.sv
rtl/multi_channel_pulse_train_generator_top.sv
bench/pulse_train_checker.sv
bench/tb_multi_channel_pulse_train_generator_top.sv
